// ===== hw/rtl/ilt_pkg.sv =====
package ilt_pkg;

    localparam int MODE_W = 2;
    localparam int CODE_W = 8;
    localparam int KIND_W = 3;
    localparam int FIELD_COL_W = 12;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [1:0] seen_t;

    localparam mode_t MODE_WS    = 2'd0;
    localparam mode_t MODE_TOKEN = 2'd1;
    localparam mode_t MODE_OPEN  = 2'd2;
    localparam mode_t MODE_CLOSE = 2'd3;

    localparam kind_t KIND_NEWLINE  = 3'd0;
    localparam kind_t KIND_INDENT   = 3'd1;
    localparam kind_t KIND_UNINDENT = 3'd2;
    localparam kind_t KIND_ERROR    = 3'd3;
    localparam kind_t KIND_MIXED    = 3'd4;
    localparam kind_t KIND_PAREN    = 3'd5;
    localparam kind_t KIND_OVERFLOW = 3'd6;

    localparam code_t CHAR_NL    = 8'd10;
    localparam code_t CHAR_TAB   = 8'd9;
    localparam code_t CHAR_SPACE = 8'd32;

    localparam seen_t SEEN_NONE  = 2'd0;
    localparam seen_t SEEN_SPACE = 2'd1;
    localparam seen_t SEEN_TAB   = 2'd2;

endpackage

// ===== hw/rtl/ilt_ram.sv =====
module ilt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/indent_layout_tracker_top.sv =====
// Offside-rule layout tracker.
// Input channel (in_valid/in_ready): one classified character event per
// transfer: whitespace byte, token start, open paren or close paren.
// Output channel (out_valid/out_ready): layout results (newline, indent,
// unindent, layout error, mixed indent, paren saved, overflow); last marks
// the final result caused by an input item. Items that cause no result give
// no transfer.
// An item is taken when idle and worked in dispatch the cycle after. A token
// start then goes to drain, which pops one unindent per cycle while the output
// register is free, then ends the item or, after a newline, goes to the layout
// decision; an overflow result comes first if the push would be dropped, and
// drain runs again when unindents follow the layout. The entry below the top is
// held in a register and refilled from the stack RAM, whose registered read is
// forwarded into the next pop. A result sits on the output register the cycle
// after the state that makes it; for whitespace and paren items that is the
// cycle after dispatch. A due result that finds the output register full holds
// the sequencer until it frees up, and no new item is taken meanwhile.
// Reset leaves a one-entry stack at column zero and needs no clearing pass;
// an item may follow reset at once.
module indent_layout_tracker_top #(
    parameter int STACK_DEPTH = 32,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ilt_pkg::MODE_W-1:0]          mode,
    input  logic [ilt_pkg::CODE_W-1:0]          char_code,
    input  logic [ilt_pkg::FIELD_COL_W-1:0]     restore_indent,
    input  logic                                restore_flag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ilt_pkg::KIND_W-1:0]          kind,
    output logic [ilt_pkg::FIELD_COL_W-1:0]     saved_indent,
    output logic                                saved_flag,
    output logic                                last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int FW = ilt_pkg::FIELD_COL_W;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_DISPATCH = 2'd1;
    localparam logic [1:0] ST_DRAIN    = 2'd2;
    localparam logic [1:0] ST_LAYOUT   = 2'd3;

    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [CW-1:0] CNT_THREE = CW'(3);
    localparam logic [CW-1:0] CNT_FULL  = CW'(STACK_DEPTH);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    logic [1:0]                 state_reg, state_next;
    ilt_pkg::mode_t             mode_reg;
    ilt_pkg::code_t             code_reg;
    logic [COLUMN_BITS-1:0]     rind_reg;
    logic                       rflag_reg;

    logic [CW-1:0]              count_reg, count_next;
    logic [COLUMN_BITS-1:0]     top_reg, top_next;
    logic [COLUMN_BITS-1:0]     below_reg, below_next;
    logic                       fill_reg, fill_next;
    logic                       fill_zero_reg, fill_zero_next;
    logic [COLUMN_BITS-1:0]     indent_reg, indent_next;
    ilt_pkg::seen_t             seen_reg, seen_next;
    logic                       after_nl_reg, after_nl_next;
    logic [COLUMN_BITS-1:0]     col_reg, col_next;
    logic                       pending_reg, pending_next;
    logic                       ovf_done_reg, ovf_done_next;

    logic                       out_valid_reg;
    ilt_pkg::kind_t             kind_reg;
    logic [FW-1:0]              saved_indent_reg;
    logic                       saved_flag_reg;
    logic                       last_reg;

    logic                       emit;
    ilt_pkg::kind_t             e_kind;
    logic [FW-1:0]              e_saved;
    logic                       e_flag;
    logic                       e_last;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [COLUMN_BITS-1:0]     ram_wdata, ram_rdata;

    logic                       can_emit;
    logic [COLUMN_BITS-1:0]     below_eff;
    logic [CW-1:0]              cnt_m1, cnt_m3;
    logic                       full;
    logic [FW+COLUMN_BITS-1:0]  indent_wide;
    logic [COLUMN_BITS+FW-1:0]  rind_wide;
    logic                       is_space, is_tab, mixed;
    ilt_pkg::seen_t             ws_kind;
    logic                       need_push, drain_more;

    ilt_ram #(
        .WIDTH(COLUMN_BITS),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign can_emit    = !out_valid_reg || out_ready;
    assign below_eff   = fill_reg ? (fill_zero_reg ? '0 : ram_rdata) : below_reg;
    assign cnt_m1      = count_reg - CNT_ONE;
    assign cnt_m3      = count_reg - CNT_THREE;
    assign full        = (count_reg == CNT_FULL);
    assign indent_wide = {{FW{1'b0}}, indent_reg};
    assign rind_wide   = {{COLUMN_BITS{1'b0}}, restore_indent};
    assign is_space    = (code_reg == ilt_pkg::CHAR_SPACE);
    assign is_tab      = (code_reg == ilt_pkg::CHAR_TAB);
    assign ws_kind     = is_space ? ilt_pkg::SEEN_SPACE : ilt_pkg::SEEN_TAB;
    assign mixed       = after_nl_reg && (is_space || is_tab)
                         && (seen_reg != ilt_pkg::SEEN_NONE) && (seen_reg != ws_kind);
    assign need_push   = pending_reg || (col_reg > indent_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        below_next     = below_eff;
        fill_next      = 1'b0;
        fill_zero_next = fill_zero_reg;
        indent_next    = indent_reg;
        seen_next      = seen_reg;
        after_nl_next  = after_nl_reg;
        col_next       = col_reg;
        pending_next   = pending_reg;
        ovf_done_next  = ovf_done_reg;
        emit           = 1'b0;
        e_kind         = ilt_pkg::KIND_NEWLINE;
        e_saved        = '0;
        e_flag         = 1'b0;
        e_last         = 1'b1;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = cnt_m3[AW-1:0];
        drain_more     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (mode_reg)
                    ilt_pkg::MODE_WS:
                    begin
                        if (code_reg == ilt_pkg::CHAR_NL)
                        begin
                            after_nl_next = 1'b1;
                            col_next      = '0;
                            state_next    = ST_IDLE;
                        end
                        else if (!mixed || can_emit)
                        begin
                            if (col_reg != COL_MAX)
                            begin
                                col_next = col_reg + COLUMN_BITS'(1);
                            end
                            if (after_nl_reg && (is_space || is_tab)
                                && (seen_reg == ilt_pkg::SEEN_NONE))
                            begin
                                seen_next = ws_kind;
                            end
                            emit       = mixed;
                            e_kind     = ilt_pkg::KIND_MIXED;
                            state_next = ST_IDLE;
                        end
                    end
                    ilt_pkg::MODE_TOKEN:
                    begin
                        state_next = ST_DRAIN;
                    end
                    ilt_pkg::MODE_OPEN:
                    begin
                        if (can_emit)
                        begin
                            emit         = 1'b1;
                            e_kind       = ilt_pkg::KIND_PAREN;
                            e_saved      = indent_wide[FW-1:0];
                            e_flag       = pending_reg;
                            pending_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    ilt_pkg::MODE_CLOSE:
                    begin
                        indent_next = rind_reg;
                        if (!pending_reg && (rind_reg == top_reg) && (count_reg > CNT_ONE))
                        begin
                            count_next     = cnt_m1;
                            top_next       = below_eff;
                            ram_re         = 1'b1;
                            fill_next      = 1'b1;
                            fill_zero_next = (count_reg <= CNT_THREE);
                        end
                        pending_next = rflag_reg;
                        state_next   = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DRAIN:
            begin
                if ((count_reg > CNT_ONE) && (top_reg > indent_reg))
                begin
                    if (can_emit)
                    begin
                        count_next     = cnt_m1;
                        top_next       = below_eff;
                        ram_re         = 1'b1;
                        fill_next      = 1'b1;
                        fill_zero_next = (count_reg <= CNT_THREE);
                        emit           = 1'b1;
                        e_kind         = ilt_pkg::KIND_UNINDENT;
                        e_last         = !after_nl_reg
                                         && !((cnt_m1 > CNT_ONE) && (below_eff > indent_reg));
                    end
                end
                else
                begin
                    ovf_done_next = 1'b0;
                    state_next    = after_nl_reg ? ST_LAYOUT : ST_IDLE;
                end
            end
            ST_LAYOUT:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (need_push && full && !ovf_done_reg)
                    begin
                        // push will be dropped: report it ahead of the layout result
                        e_kind        = ilt_pkg::KIND_OVERFLOW;
                        e_last        = 1'b0;
                        ovf_done_next = 1'b1;
                    end
                    else
                    begin
                        ovf_done_next = 1'b0;
                        after_nl_next = 1'b0;
                        if (pending_reg)
                        begin
                            if (!full)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = indent_reg;
                                below_next = top_reg;
                                top_next   = indent_reg;
                                count_next = count_reg + CNT_ONE;
                            end
                            indent_next  = col_reg;
                            pending_next = 1'b0;
                            e_kind       = ilt_pkg::KIND_NEWLINE;
                        end
                        else if (col_reg > indent_reg)
                        begin
                            if (!full)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = col_reg;
                                below_next = top_reg;
                                top_next   = col_reg;
                                count_next = count_reg + CNT_ONE;
                            end
                            indent_next = col_reg;
                            e_kind      = ilt_pkg::KIND_INDENT;
                        end
                        else if (col_reg < top_reg)
                        begin
                            if (count_reg > CNT_ONE)
                            begin
                                count_next     = cnt_m1;
                                top_next       = below_eff;
                                ram_re         = 1'b1;
                                fill_next      = 1'b1;
                                fill_zero_next = (count_reg <= CNT_THREE);
                            end
                            indent_next = col_reg;
                            e_kind      = (top_next < col_reg) ? ilt_pkg::KIND_ERROR
                                                               : ilt_pkg::KIND_UNINDENT;
                        end
                        else
                        begin
                            e_kind = ilt_pkg::KIND_NEWLINE;
                        end
                        drain_more = (count_next > CNT_ONE) && (top_next > indent_next);
                        e_last     = !drain_more;
                        state_next = drain_more ? ST_DRAIN : ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_ONE;
            top_reg       <= '0;
            below_reg     <= '0;
            fill_reg      <= 1'b0;
            fill_zero_reg <= 1'b0;
            indent_reg    <= '0;
            seen_reg      <= ilt_pkg::SEEN_NONE;
            after_nl_reg  <= 1'b0;
            col_reg       <= '0;
            pending_reg   <= 1'b0;
            ovf_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            below_reg     <= below_next;
            fill_reg      <= fill_next;
            fill_zero_reg <= fill_zero_next;
            indent_reg    <= indent_next;
            seen_reg      <= seen_next;
            after_nl_reg  <= after_nl_next;
            col_reg       <= col_next;
            pending_reg   <= pending_next;
            ovf_done_reg  <= ovf_done_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg  <= mode;
            code_reg  <= char_code;
            rind_reg  <= rind_wide[COLUMN_BITS-1:0];
            rflag_reg <= restore_flag;
        end
        if (emit)
        begin
            kind_reg         <= e_kind;
            saved_indent_reg <= e_saved;
            saved_flag_reg   <= e_flag;
            last_reg         <= e_last;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign saved_indent = saved_indent_reg;
    assign saved_flag   = saved_flag_reg;
    assign last         = last_reg;

endmodule
